// ===== rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg: shared types, S-box and GF(2^8) helpers for the AES-128 pipeline
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam logic [7:0] GF_POLY = 8'h1B;
    localparam logic [0:0] CFG_KEY_HI = 1'b0;
    localparam logic [0:0] CFG_KEY_LO = 1'b1;

    typedef logic [127:0] t_block;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    // byte i of a block sits at bits 127-8i
    function automatic logic [7:0] get_byte(input t_block b, input int i);
        get_byte = b[127 - 8 * i -: 8];
    endfunction

endpackage

// ===== rtl/block_cipher_encrypt_128_top.sv =====
// ----------------------------------------------------------------------------
// block_cipher_encrypt_128_top: AES-128 encryption, one round per stage
//
//   channel   direction  tdata fields (low bit up)
//   s_axis    in         block_hi[63:0], block_lo[127:64]
//   m_axis    out        cipher_hi[63:0], cipher_lo[127:64]
//   cfg       in         index 0 key_hi, index 1 key_lo
//
// Eleven register stages (input whitening plus ten rounds): a block passes
// the whitening register, then each round register in turn, to m_axis. One
// block per cycle, but a stall on m_axis holds the whole pipeline; s_axis is
// ready whenever the output stage can move. Reset clears valid bits and keys.
// ----------------------------------------------------------------------------
module block_cipher_encrypt_128_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // block_hi, block_lo
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // cipher_hi, cipher_lo
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [0:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data
);
    import aes_pkg::*;

    logic [63:0] r_key_hi, r_key_lo;
    logic        r_v0;
    t_block      r_s0, r_k0;
    logic        en;
    logic        v   [NUM_ROUNDS + 1];
    t_block      st  [NUM_ROUNDS + 1];
    t_block      ky  [NUM_ROUNDS + 1];
    logic [7:0]  rc  [NUM_ROUNDS];

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_v0     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_KEY_HI) begin
                    r_key_hi <= i_cfg_data;
                end else begin
                    r_key_lo <= i_cfg_data;
                end
            end
            if (en) begin
                r_v0 <= s_axis_tvalid;
            end
        end
        if (en) begin
            r_s0 <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ {r_key_hi, r_key_lo};
            r_k0 <= {r_key_hi, r_key_lo};
        end
    end

    assign v[0]  = r_v0;
    assign st[0] = r_s0;
    assign ky[0] = r_k0;

    always_comb begin
        rc[0] = 8'h01;
        for (int i = 1; i < NUM_ROUNDS; i++) begin
            rc[i] = gf_dbl(rc[i - 1]);
        end
    end

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        aes_round #(.LAST(g == NUM_ROUNDS - 1)) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_state (st[g]),
            .i_key   (ky[g]),
            .i_rcon  (rc[g]),
            .o_valid (v[g + 1]),
            .o_state (st[g + 1]),
            .o_key   (ky[g + 1])
        );
    end

    assign m_axis_tvalid = v[NUM_ROUNDS];
    assign m_axis_tdata  = {st[NUM_ROUNDS][63:0], st[NUM_ROUNDS][127:64]};
endmodule

// ===== rtl/aes_round.sv =====
// ----------------------------------------------------------------------------
// aes_round: one registered cipher round with its key expansion step
// ----------------------------------------------------------------------------
module aes_round #(
    parameter bit LAST = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  aes_pkg::t_block   i_state,
    input  aes_pkg::t_block   i_key,
    input  logic [7:0]        i_rcon,
    output logic              o_valid,
    output aes_pkg::t_block   o_state,
    output aes_pkg::t_block   o_key
);
    import aes_pkg::*;

    logic [7:0] sb [16];
    logic [7:0] sr [16];
    logic [7:0] mc [16];
    logic [7:0] kb [16];
    logic [7:0] nk [16];
    t_block     n_state, n_key;
    t_block     r_state, r_key;
    logic       r_valid;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sb[i] = SBOX[get_byte(i_state, i)];
            kb[i] = get_byte(i_key, i);
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sr[r + 4 * c] = sb[r + 4 * ((c + r) % 4)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            mc[4*c]   = gf_dbl(sr[4*c]) ^ gf_dbl(sr[4*c+1]) ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
            mc[4*c+1] = sr[4*c] ^ gf_dbl(sr[4*c+1]) ^ gf_dbl(sr[4*c+2]) ^ sr[4*c+2] ^ sr[4*c+3];
            mc[4*c+2] = sr[4*c] ^ sr[4*c+1] ^ gf_dbl(sr[4*c+2]) ^ gf_dbl(sr[4*c+3]) ^ sr[4*c+3];
            mc[4*c+3] = gf_dbl(sr[4*c]) ^ sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ gf_dbl(sr[4*c+3]);
        end
        nk[0] = kb[0] ^ SBOX[kb[13]] ^ i_rcon;
        nk[1] = kb[1] ^ SBOX[kb[14]];
        nk[2] = kb[2] ^ SBOX[kb[15]];
        nk[3] = kb[3] ^ SBOX[kb[12]];
        for (int i = 4; i < 16; i++) begin
            nk[i] = kb[i] ^ nk[i - 4];
        end
        for (int i = 0; i < 16; i++) begin
            n_key[127 - 8 * i -: 8]   = nk[i];
            n_state[127 - 8 * i -: 8] = (LAST ? sr[i] : mc[i]) ^ nk[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;
endmodule
